>>> hw/rtl/swnpv_pkg.sv
package swnpv_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PAY  = 2'd1,
    OP_EVAL = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RD2,
    S_MUL,
    S_DEN,
    S_ACC,
    S_FLT,
    S_FX1,
    S_FX2,
    S_NPV,
    S_DIV,
    S_WB,
    S_FIN
  } state_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_ANN  = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam logic [1:0] CFG_FLOAT_ACCRUAL = 2'd0;
  localparam logic [1:0] CFG_STRIKE_RATE   = 2'd1;
  localparam logic [1:0] CFG_START_INDEX   = 2'd2;
  localparam logic [1:0] CFG_END_INDEX     = 2'd3;

  localparam logic [31:0] ONE_Q131       = 32'h8000_0000;
  localparam logic [31:0] FA_RESET       = 32'd268435456;
  localparam logic [40:0] ANN_MAX        = {41{1'b1}};
  localparam logic [39:0] NPV_MAX        = {1'b0, {39{1'b1}}};
  localparam logic [39:0] NPV_MIN        = {1'b1, {39{1'b0}}};

endpackage

>>> hw/rtl/swnpv_ifs.sv
interface swnpv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] forward_rate;
  logic [6:0]  pay_index;
  logic [31:0] pay_accrual;
  modport source (output valid, opcode, forward_rate, pay_index, pay_accrual, input ready);
  modport sink   (input valid, opcode, forward_rate, pay_index, pay_accrual, output ready);
endinterface

interface swnpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] swap_npv;
  logic [31:0]        par_rate;
  logic [1:0]         status;
  modport source (output valid, swap_npv, par_rate, status, input ready);
  modport sink   (input valid, swap_npv, par_rate, status, output ready);
endinterface

interface swnpv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/swap_npv_and_par_rate_core.sv
// channel  dir  payload                                        handshake
// in_if    in   opcode, forward_rate, pay_index, pay_accrual   valid/ready
// out_if   out  swap_npv, par_rate, status                     valid/ready
// cfg_if   in   index, data                                    valid/ready, always ready
//
// Rate load: table read, multiply, then the 32-step restoring divider and write-back.
// Payment: table read, multiply, accumulate.
// Evaluate: divides only for a par rate in (0,1); bad indices go straight to S_FIN.
// Reset: synchronous, active low; no clearing pass, entry zero of the table is a constant.
// Input is taken only in idle; an evaluate result waits in S_FIN while the output is full.
module swap_npv_and_par_rate_core
  import swnpv_pkg::*;
#(
  parameter int MAX_HORIZON = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  swnpv_in_if.sink     in_if,
  swnpv_out_if.source  out_if,
  swnpv_cfg_if.sink    cfg_if
);

  localparam int AW   = $clog2(MAX_HORIZON + 1);
  localparam int CMPW = (AW > 7) ? AW : 7;
  localparam int DEPTH = MAX_HORIZON + 1;

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [31:0] fa_r, strike_r;
  logic [6:0]  start_r, end_r;

  logic [AW-1:0] rl_r;
  logic [40:0]   ann_r;
  logic          fault_r;

  logic [31:0] word_r;
  logic [6:0]  idx_r;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_q_r;
  logic        rd_zero_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [31:0]   zc;

  logic [63:0]        prod_r;
  logic [31:0]        z_r;
  logic [31:0]        za_r;
  logic signed [33:0] flt_r;
  logic [41:0]        fixed_r;

  logic [40:0] div_rem_r, div_den_r;
  logic [31:0] div_q_r;
  logic [4:0]  div_cnt_r;
  logic [41:0] div_t;
  logic        div_ge;
  logic [40:0] div_rem_step;
  logic [31:0] div_q_step;

  logic signed [39:0] npv_r;
  logic [31:0]        par_r;
  logic [1:0]         stat_r;

  logic               out_valid_r;
  logic signed [39:0] out_npv_r;
  logic [31:0]        out_par_r;
  logic [1:0]         out_stat_r;

  logic in_acc, out_free;
  logic load_full, pay_bad, eval_bad;
  logic [41:0] ann_sum;
  logic signed [43:0] npv_w;
  logic flt_pos;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  assign load_full = (CMPW'(rl_r) >= CMPW'(MAX_HORIZON));
  assign pay_bad   = (CMPW'(in_if.pay_index) > CMPW'(rl_r)) ||
                     (CMPW'(in_if.pay_index) > CMPW'(MAX_HORIZON));
  assign eval_bad  = fault_r || (start_r == 7'd0) ||
                     (CMPW'(start_r - 7'd1) > CMPW'(rl_r)) ||
                     (CMPW'(end_r) > CMPW'(rl_r)) ||
                     (CMPW'(end_r) > CMPW'(MAX_HORIZON));

  assign zc = rd_zero_r ? ONE_Q131 : rd_q_r;

  assign div_t        = {div_rem_r, 1'b0};
  assign div_ge       = div_t >= {1'b0, div_den_r};
  assign div_rem_step = div_ge ? 41'(div_t - {1'b0, div_den_r}) : div_t[40:0];
  assign div_q_step   = {div_q_r[30:0], div_ge};

  assign ann_sum = {1'b0, ann_r} + 42'(prod_r[63:29]);
  assign npv_w   = 44'(flt_r) - $signed({2'b00, fixed_r});
  assign flt_pos = !flt_r[33] && (flt_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_if.opcode)
            OP_LOAD: state_nxt = load_full ? S_IDLE : S_RD;
            OP_PAY:  state_nxt = pay_bad ? S_IDLE : S_RD;
            OP_EVAL: state_nxt = eval_bad ? S_FIN : S_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:  state_nxt = (op_r == OP_EVAL) ? S_RD2 : S_MUL;
      S_RD2: state_nxt = S_FLT;
      S_MUL: state_nxt = (op_r == OP_LOAD) ? S_DEN : S_ACC;
      S_DEN: state_nxt = S_DIV;
      S_ACC: state_nxt = S_IDLE;
      S_FLT: state_nxt = S_FX1;
      S_FX1: state_nxt = S_FX2;
      S_FX2: state_nxt = S_NPV;
      S_NPV: begin
        if (ann_r != '0 && flt_pos && (41'(flt_r) < ann_r)) state_nxt = S_DIV;
        else state_nxt = S_FIN;
      end
      S_DIV: begin
        if (div_cnt_r == 5'd0) state_nxt = (op_r == OP_LOAD) ? S_WB : S_FIN;
      end
      S_WB:  state_nxt = S_IDLE;
      S_FIN: state_nxt = out_free ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_if.ready = (state_r == S_IDLE);
    mem_we      = (state_r == S_WB);
    rd_addr     = rl_r;
    case (state_r)
      S_RD: begin
        case (op_r)
          OP_PAY:  rd_addr = AW'(idx_r);
          OP_EVAL: rd_addr = AW'(start_r - 7'd1);
          default: rd_addr = rl_r;
        endcase
      end
      S_RD2:   rd_addr = AW'(end_r);
      default: rd_addr = rl_r;
    endcase
  end

  assign cfg_if.ready    = 1'b1;
  assign out_if.valid    = out_valid_r;
  assign out_if.swap_npv = out_npv_r;
  assign out_if.par_rate = out_par_r;
  assign out_if.status   = out_stat_r;

  // discount table; entry zero is the constant one
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(rl_r + AW'(1))] <= div_q_r;
    end
    rd_q_r    <= mem[rd_addr];
    rd_zero_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fa_r        <= FA_RESET;
      strike_r    <= '0;
      start_r     <= 7'd1;
      end_r       <= 7'd1;
      rl_r        <= '0;
      ann_r       <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_if.valid) begin
        case (cfg_if.index)
          CFG_FLOAT_ACCRUAL: fa_r     <= cfg_if.data;
          CFG_STRIKE_RATE:   strike_r <= cfg_if.data;
          CFG_START_INDEX:   start_r  <= cfg_if.data[6:0];
          CFG_END_INDEX:     end_r    <= cfg_if.data[6:0];
          default: ;
        endcase
      end

      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_if.opcode)
              OP_LOAD: begin
                op_r   <= OP_LOAD;
                word_r <= in_if.forward_rate;
              end
              OP_PAY: begin
                op_r   <= OP_PAY;
                word_r <= in_if.pay_accrual;
                idx_r  <= in_if.pay_index;
                if (pay_bad) fault_r <= 1'b1;
              end
              OP_EVAL: begin
                op_r   <= OP_EVAL;
                npv_r  <= '0;
                par_r  <= '0;
                stat_r <= ST_BAD_INDEX;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod_r <= 64'(word_r) * 64'((op_r == OP_LOAD) ? fa_r : zc);
          z_r    <= zc;
        end
        S_DEN: begin
          div_rem_r <= 41'(z_r);
          div_den_r <= 41'(prod_r[63:30]) + (41'(1) << 32);
          div_q_r   <= '0;
          div_cnt_r <= 5'd31;
        end
        S_ACC: begin
          ann_r <= ann_sum[41] ? ANN_MAX : ann_sum[40:0];
        end
        S_RD2: za_r <= zc;
        S_FLT: flt_r <= $signed({1'b0, za_r, 1'b0}) - $signed({1'b0, zc, 1'b0});
        S_FX1: prod_r <= 64'(strike_r) * 64'(ann_r[31:0]);
        S_FX2: fixed_r <= 42'(41'(strike_r) * 41'(ann_r[40:32])) + 42'(prod_r[63:32]);
        S_NPV: begin
          if (npv_w[43:39] != {5{npv_w[43]}}) begin
            npv_r <= npv_w[43] ? NPV_MIN : NPV_MAX;
          end else begin
            npv_r <= npv_w[39:0];
          end
          stat_r    <= (ann_r == '0) ? ST_ZERO_ANN : ST_OK;
          par_r     <= (ann_r != '0 && flt_pos && (41'(flt_r) >= ann_r)) ? '1 : '0;
          div_rem_r <= 41'(flt_r);
          div_den_r <= ann_r;
          div_q_r   <= '0;
          div_cnt_r <= 5'd31;
        end
        S_DIV: begin
          div_rem_r <= div_rem_step;
          div_q_r   <= div_q_step;
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd0 && op_r == OP_EVAL) par_r <= div_q_step;
        end
        S_WB: rl_r <= AW'(rl_r + AW'(1));
        S_FIN: begin
          if (out_free) begin
            out_npv_r   <= npv_r;
            out_par_r   <= par_r;
            out_stat_r  <= stat_r;
            rl_r        <= '0;
            ann_r       <= '0;
            fault_r     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(rl_r) <= CMPW'(MAX_HORIZON))
    else $error("load count beyond horizon");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_stat_r == ST_OK || out_stat_r == ST_ZERO_ANN ||
                     out_stat_r == ST_BAD_INDEX))
    else $error("bad status code");

  a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (rl_r == '0 && ann_r == '0 && !fault_r))
    else $error("evaluate did not clear state");
`endif

endmodule
